/* design/sfp_pkg.sv */
package sfp_pkg;

   localparam int ValW   = 14;
   localparam int LimW   = 7;
   localparam int PerW   = 8;
   localparam int AddrW  = 5;
   localparam int DataW  = 32;

   localparam logic [7:0] START_CHAR = 8'h4D;
   localparam logic [7:0] END_CHAR   = 8'h4E;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] NODE_ONE   = 8'h31;
   localparam logic [7:0] NODE_TWO   = 8'h32;
   localparam logic [ValW-1:0] SCALE = ValW'(100);

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic {
      KIND_REPORT = 1'b0,
      KIND_UPDATE = 1'b1
   } kind_type;

   // register index, taken from paddr[4:2]
   localparam logic [2:0] REG_TEMP_ONE  = 3'd0;
   localparam logic [2:0] REG_TEMP_TWO  = 3'd1;
   localparam logic [2:0] REG_HUMID_ONE = 3'd2;
   localparam logic [2:0] REG_HUMID_TWO = 3'd3;
   localparam logic [2:0] REG_PERIOD    = 3'd4;

   localparam logic [LimW-1:0] TEMP_ONE_RST  = LimW'(40);
   localparam logic [LimW-1:0] TEMP_TWO_RST  = LimW'(39);
   localparam logic [LimW-1:0] HUMID_ONE_RST = LimW'(70);
   localparam logic [LimW-1:0] HUMID_TWO_RST = LimW'(69);
   localparam logic [PerW-1:0] PERIOD_RST    = PerW'(20);

   typedef struct packed {
      logic [1:0][LimW-1:0] temp_lim;
      logic [1:0][LimW-1:0] humid_lim;
      logic [PerW-1:0]      period;
   } cfg_type;

   typedef struct packed {
      kind_type        kind;
      logic [1:0]      node_id;
      logic [ValW-1:0] humidity;
      logic [ValW-1:0] temperature;
      logic            temp_alarm;
      logic            humid_alarm;
   } rsp_type;

   function automatic logic [ValW-1:0] scale_limit(input logic [LimW-1:0] lim);
      return ValW'(lim) * SCALE;
   endfunction

endpackage

/* design/sfp_csr.sv */
module sfp_csr
   import sfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [AddrW-1:0] csr_paddr,
   input  logic [DataW-1:0] csr_pwdata,
   output logic [DataW-1:0] csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[4:2])
            REG_TEMP_ONE:  cfg_in.temp_lim[0]  = csr_pwdata[LimW-1:0];
            REG_TEMP_TWO:  cfg_in.temp_lim[1]  = csr_pwdata[LimW-1:0];
            REG_HUMID_ONE: cfg_in.humid_lim[0] = csr_pwdata[LimW-1:0];
            REG_HUMID_TWO: cfg_in.humid_lim[1] = csr_pwdata[LimW-1:0];
            REG_PERIOD:    cfg_in.period       = csr_pwdata[PerW-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_lim[0]  <= TEMP_ONE_RST;
         cfg_ff.temp_lim[1]  <= TEMP_TWO_RST;
         cfg_ff.humid_lim[0] <= HUMID_ONE_RST;
         cfg_ff.humid_lim[1] <= HUMID_TWO_RST;
         cfg_ff.period       <= PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_TEMP_ONE:  csr_prdata = DataW'(cfg_ff.temp_lim[0]);
         REG_TEMP_TWO:  csr_prdata = DataW'(cfg_ff.temp_lim[1]);
         REG_HUMID_ONE: csr_prdata = DataW'(cfg_ff.humid_lim[0]);
         REG_HUMID_TWO: csr_prdata = DataW'(cfg_ff.humid_lim[1]);
         REG_PERIOD:    csr_prdata = DataW'(cfg_ff.period);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* design/sfp_core.sv */
module sfp_core
   import sfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic       cmd,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output logic       res_valid,
   output rsp_type    res
);

   logic [3:0]            pos_ff, pos_in;
   logic [1:0]            node_ff, node_in;
   logic                  bad_ff, bad_in;
   logic [ValW-1:0]       hacc_ff, hacc_in;
   logic [ValW-1:0]       tacc_ff, tacc_in;
   logic [1:0][ValW-1:0]  hum_ff, hum_in;
   logic [1:0][ValW-1:0]  tmp_ff, tmp_in;
   logic [PerW-1:0]       tick_ff, tick_in;
   logic [PerW-1:0]       tick_sum;
   logic                  is_digit;
   logic [ValW-1:0]       digit;
   logic                  slot;

   assign is_digit = (rx_byte >= DIGIT_ZERO) && (rx_byte <= DIGIT_ZERO + 8'd9);
   assign digit    = is_digit ? ValW'(rx_byte[3:0]) : '0;
   assign tick_sum = tick_ff + PerW'(1);
   assign slot     = node_ff[1];

   function automatic logic [ValW-1:0] mac10(input logic [ValW-1:0] acc,
                                             input logic [ValW-1:0] d);
      return (acc << 3) + (acc << 1) + d;
   endfunction

   always_comb begin
      pos_in    = pos_ff;
      node_in   = node_ff;
      bad_in    = bad_ff;
      hacc_in   = hacc_ff;
      tacc_in   = tacc_ff;
      hum_in    = hum_ff;
      tmp_in    = tmp_ff;
      tick_in   = tick_ff;
      res_valid = 1'b0;
      res       = '0;
      if (step_en) begin
         if (cmd == CMD_TICK) begin
            if (tick_sum < cfg.period) begin
               tick_in = tick_sum;
            end else begin
               tick_in   = '0;
               res_valid = 1'b1;
            end
         end else if (rx_byte == START_CHAR) begin
            pos_in  = 4'd1;
            node_in = '0;
            bad_in  = 1'b0;
            hacc_in = '0;
            tacc_in = '0;
         end else begin
            case (pos_ff) inside
               4'd0, [4'd11:4'd15]: begin
                  pos_in = '0;
               end
               4'd1: begin
                  pos_in = pos_ff + 4'd1;
                  if (rx_byte == NODE_ONE) begin
                     node_in = 2'd1;
                  end else if (rx_byte == NODE_TWO) begin
                     node_in = 2'd2;
                  end else begin
                     node_in = '0;
                     bad_in  = 1'b1;
                  end
               end
               [4'd2:4'd5]: begin
                  pos_in  = pos_ff + 4'd1;
                  bad_in  = bad_ff || !is_digit;
                  hacc_in = mac10(hacc_ff, digit);
               end
               [4'd6:4'd9]: begin
                  pos_in  = pos_ff + 4'd1;
                  bad_in  = bad_ff || !is_digit;
                  tacc_in = mac10(tacc_ff, digit);
               end
               4'd10: begin
                  pos_in = '0;
                  if (rx_byte == END_CHAR && !bad_ff && (node_ff == 2'd1 || node_ff == 2'd2))
                  begin
                     hum_in[slot]    = hacc_ff;
                     tmp_in[slot]    = tacc_ff;
                     res_valid       = 1'b1;
                     res.kind        = KIND_UPDATE;
                     res.node_id     = node_ff;
                     res.humidity    = hacc_ff;
                     res.temperature = tacc_ff;
                  end
               end
               default: pos_in = '0;
            endcase
         end
      end
      // alarms look at the stored values after this request's update
      res.temp_alarm  = (scale_limit(cfg.temp_lim[0]) < tmp_in[0]) ||
                        (scale_limit(cfg.temp_lim[1]) < tmp_in[1]);
      res.humid_alarm = (scale_limit(cfg.humid_lim[0]) < hum_in[0]) ||
                        (scale_limit(cfg.humid_lim[1]) < hum_in[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         node_ff <= '0;
         bad_ff  <= 1'b0;
         hacc_ff <= '0;
         tacc_ff <= '0;
         hum_ff  <= '0;
         tmp_ff  <= '0;
         tick_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         node_ff <= node_in;
         bad_ff  <= bad_in;
         hacc_ff <= hacc_in;
         tacc_ff <= tacc_in;
         hum_ff  <= hum_in;
         tmp_ff  <= tmp_in;
         tick_ff <= tick_in;
      end
   end

endmodule

/* design/sensor_frame_parser_with_alarm_core.sv */
// Channel  | Ports                                   | Moves
// ---------+-----------------------------------------+-------------------------------
// request  | req_valid/req_ready, req_cmd, req_rx_byte | one byte or one timer tick
// result   | rsp_valid/rsp_ready, rsp_*               | update or periodic alarm report
// config   | csr_* (APB-style, pready tied high)      | limits and report period
//
// One request per cycle unless results stall; results pass request and result registers.
// Parser, node store and alarm compare sit between the request and result registers.
// Reset (synchronous, active high) clears the parser, stored values and tick count and
// loads the register defaults.
// A stalled result holds the result register; one more request may wait in the request
// register, after which req_ready drops until rsp_ready returns.
module sensor_frame_parser_with_alarm_core
   import sfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_cmd,
   input  logic [7:0]       req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_kind,
   output logic [1:0]       rsp_node_id,
   output logic [ValW-1:0]  rsp_humidity,
   output logic [ValW-1:0]  rsp_temperature,
   output logic             rsp_temp_alarm,
   output logic             rsp_humid_alarm,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [AddrW-1:0] csr_paddr,
   input  logic [DataW-1:0] csr_pwdata,
   output logic [DataW-1:0] csr_prdata,
   output logic             csr_pready
);

   cfg_type    cfg;
   rsp_type    res;
   logic       res_valid;
   logic       advance;

   logic       in_valid_ff, in_valid_in;
   logic       in_cmd_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;

   sfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sfp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .cmd       (in_cmd_ff),
      .rx_byte   (in_byte_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   // a request leaves the input register whenever the result register is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = res_valid;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff  <= req_cmd;
         in_byte_ff <= req_rx_byte;
      end
      if (advance && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_ff.kind;
   assign rsp_node_id     = out_ff.node_id;
   assign rsp_humidity    = out_ff.humidity;
   assign rsp_temperature = out_ff.temperature;
   assign rsp_temp_alarm  = out_ff.temp_alarm;
   assign rsp_humid_alarm = out_ff.humid_alarm;

`ifndef SYNTHESIS
   a_ready_low_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("request stage blocked without a stalled result");

   a_update_node_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_UPDATE |-> rsp_node_id == 2'd1 || rsp_node_id == 2'd2)
      else $error("update result with unknown node");

   a_report_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_REPORT |->
         rsp_node_id == '0 && rsp_humidity == '0 && rsp_temperature == '0)
      else $error("report result carries frame data");

   a_result_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(in_valid_ff))
      else $error("result appeared with no request in flight");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import sfp_pkg::*;

   localparam int ItemsPerPhase = 205;
   localparam int WatchdogLimit = 3000;
   localparam int LongHold      = 80;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
   } req_item_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_cmd = CMD_BYTE;
   logic [7:0]       req_rx_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_kind;
   logic [1:0]       rsp_node_id;
   logic [ValW-1:0]  rsp_humidity;
   logic [ValW-1:0]  rsp_temperature;
   logic             rsp_temp_alarm;
   logic             rsp_humid_alarm;
   logic             csr_psel = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite = 1'b0;
   logic [AddrW-1:0] csr_paddr = '0;
   logic [DataW-1:0] csr_pwdata = '0;
   logic [DataW-1:0] csr_prdata;
   logic             csr_pready;

   // predictor state and register copy
   logic [LimW-1:0] lim_tmp[2] = '{TEMP_ONE_RST, TEMP_TWO_RST};
   logic [LimW-1:0] lim_hum[2] = '{HUMID_ONE_RST, HUMID_TWO_RST};
   logic [PerW-1:0] period_cfg = PERIOD_RST;
   logic [3:0]      frame_pos = '0;
   logic [1:0]      frame_node = '0;
   logic            frame_bad = 1'b0;
   logic [ValW-1:0] hum_acc = '0;
   logic [ValW-1:0] tmp_acc = '0;
   logic [ValW-1:0] stored_hum[2] = '{'0, '0};
   logic [ValW-1:0] stored_tmp[2] = '{'0, '0};
   logic [PerW-1:0] tick_cnt = '0;

   req_item_type req_backlog[$];
   rsp_type      due_results[$];
   rsp_type      next_rsp;
   rsp_type      want;
   req_item_type cur;

   logic req_took = 1'b0;
   logic rsp_took = 1'b0;
   logic req_live = 1'b0;
   logic drv_next;
   bit   no_idle = 1'b0;
   int   req_gap = 0;
   int   rsp_gap = 0;
   int   hold_asks = 0;
   int   hold_seen = 0;
   int   hold_left = 0;
   int   stall_cycles = 0;
   int   errors = 0;
   int   n_queued = 0;
   int   n_requests = 0;
   int   n_updates = 0;
   int   n_reports = 0;
   int   n_settings = 0;

   sensor_frame_parser_with_alarm_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_node_id     (rsp_node_id),
      .rsp_humidity    (rsp_humidity),
      .rsp_temperature (rsp_temperature),
      .rsp_temp_alarm  (rsp_temp_alarm),
      .rsp_humid_alarm (rsp_humid_alarm),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic bit over_limit(input logic [LimW-1:0] lim_a, input logic [LimW-1:0] lim_b,
                                     input logic [ValW-1:0] val_a, input logic [ValW-1:0] val_b);
      return (int'(lim_a) * int'(SCALE) < int'(val_a)) ||
             (int'(lim_b) * int'(SCALE) < int'(val_b));
   endfunction

   // advances the parser and tick counter by one request; 1 when a result is due
   function automatic bit predict_event(input logic cmd, input logic [7:0] b,
                                        output rsp_type res);
      logic [3:0]      pos;
      bit              dig;
      logic [ValW-1:0] d;
      int              slot;
      res = '0;
      if (cmd == CMD_TICK) begin
         tick_cnt = tick_cnt + 8'd1;
         if (tick_cnt < period_cfg) return 1'b0;
         tick_cnt = '0;
         res.kind = KIND_REPORT;
         res.temp_alarm = over_limit(lim_tmp[0], lim_tmp[1], stored_tmp[0], stored_tmp[1]);
         res.humid_alarm = over_limit(lim_hum[0], lim_hum[1], stored_hum[0], stored_hum[1]);
         return 1'b1;
      end
      pos = frame_pos;
      dig = (b >= DIGIT_ZERO) && (b <= DIGIT_ZERO + 8'd9);
      d = dig ? ValW'(b - DIGIT_ZERO) : '0;
      if (b == START_CHAR) begin
         frame_pos = 4'd1;
         frame_node = '0;
         frame_bad = 1'b0;
         hum_acc = '0;
         tmp_acc = '0;
         return 1'b0;
      end
      if (pos == 4'd0 || pos > 4'd10) begin
         frame_pos = '0;
         return 1'b0;
      end
      if (pos == 4'd1) begin
         if (b == NODE_ONE) frame_node = 2'd1;
         else if (b == NODE_TWO) frame_node = 2'd2;
         else begin
            frame_node = '0;
            frame_bad = 1'b1;
         end
      end else if (pos <= 4'd5) begin
         if (!dig) frame_bad = 1'b1;
         hum_acc = hum_acc * ValW'(10) + d;
      end else if (pos <= 4'd9) begin
         if (!dig) frame_bad = 1'b1;
         tmp_acc = tmp_acc * ValW'(10) + d;
      end else begin
         frame_pos = '0;
         if (b != END_CHAR || frame_bad || frame_node == 2'd0 || frame_node == 2'd3)
            return 1'b0;
         slot = int'(frame_node) - 1;
         stored_hum[slot] = hum_acc;
         stored_tmp[slot] = tmp_acc;
         res.kind = KIND_UPDATE;
         res.node_id = frame_node;
         res.humidity = hum_acc;
         res.temperature = tmp_acc;
         res.temp_alarm = over_limit(lim_tmp[0], lim_tmp[1], stored_tmp[0], stored_tmp[1]);
         res.humid_alarm = over_limit(lim_hum[0], lim_hum[1], stored_hum[0], stored_hum[1]);
         return 1'b1;
      end
      frame_pos = pos + 4'd1;
      return 1'b0;
   endfunction

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 4);
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
      if (got_v !== exp_v) begin
         errors++;
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      end
   endtask

   // sampling, prediction, checking and watchdog
   always @(posedge clock) begin
      req_took = req_valid && req_ready;
      rsp_took = rsp_valid && rsp_ready;
      if (!reset) begin
         if (req_took) begin
            n_requests++;
            if (predict_event(req_cmd, req_rx_byte, next_rsp)) due_results.push_back(next_rsp);
         end
         if (rsp_took) begin
            if (due_results.size() == 0) begin
               errors++;
               $error("result accepted with no result outstanding");
            end else begin
               want = due_results.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("node_id", want.node_id, rsp_node_id);
               check_field("humidity", want.humidity, rsp_humidity);
               check_field("temperature", want.temperature, rsp_temperature);
               check_field("temp_alarm", want.temp_alarm, rsp_temp_alarm);
               check_field("humid_alarm", want.humid_alarm, rsp_humid_alarm);
               if (want.kind == KIND_UPDATE) n_updates++;
               else n_reports++;
            end
         end
         if (req_took || rsp_took) stall_cycles = 0;
         else begin
            stall_cycles++;
            if (stall_cycles >= WatchdogLimit) begin
               $display("CHECKS FAILED");
               $finish;
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (!reset) begin
         drv_next = req_valid;
         if (req_valid && req_took) begin
            drv_next = 1'b0;
            req_live = 1'b0;
            req_gap = draw_wait();
         end
         if (!drv_next) begin
            if (req_gap > 0) req_gap--;
            else if (req_backlog.size() > 0) begin
               cur = req_backlog.pop_front();
               req_cmd <= cur.cmd;
               req_rx_byte <= cur.data;
               drv_next = 1'b1;
               req_live = 1'b1;
            end
         end
         req_valid <= drv_next;
      end
   end

   // result receiver; a long hold-off lets the block fill and stall its input
   always @(negedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = LongHold;
      end
      if (rsp_took) rsp_gap = draw_wait();
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else rsp_ready <= 1'b1;
   end

   task automatic csr_write(input logic [2:0] idx, input int unsigned val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= AddrW'({idx, 2'b00});
      csr_pwdata <= DataW'(val);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_TEMP_ONE:  lim_tmp[0] = LimW'(val);
         REG_TEMP_TWO:  lim_tmp[1] = LimW'(val);
         REG_HUMID_ONE: lim_hum[0] = LimW'(val);
         REG_HUMID_TWO: lim_hum[1] = LimW'(val);
         REG_PERIOD:    period_cfg = PerW'(val);
         default: ;
      endcase
   endtask

   task automatic program_regs(input int t1, input int t2, input int h1, input int h2,
                               input int per);
      csr_write(REG_TEMP_ONE, t1);
      csr_write(REG_TEMP_TWO, t2);
      csr_write(REG_HUMID_ONE, h1);
      csr_write(REG_HUMID_TWO, h2);
      csr_write(REG_PERIOD, per);
      n_settings++;
   endtask

   task automatic push_item(input logic cmd, input logic [7:0] b, input bit counts);
      req_backlog.push_back('{cmd: cmd, data: b});
      if (counts) n_queued++;
   endtask

   // a byte outside [lo, hi] that is not a frame start
   function automatic logic [7:0] rand_other(input logic [7:0] lo, input logic [7:0] hi);
      logic [7:0] b;
      do b = 8'($urandom); while ((b >= lo && b <= hi) || b == START_CHAR);
      return b;
   endfunction

   // hundredths value, often right at the alarm threshold
   function automatic int pick_value(input logic [LimW-1:0] lim);
      int bound;
      bound = int'(lim) * int'(SCALE);
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 9999);
         1: bound = bound - 1;
         2: ;
         default: bound = bound + 1;
      endcase
      if (bound < 0) bound = 0;
      if (bound > 9999) bound = 9999;
      return bound;
   endfunction

   task automatic queue_frame(input logic [7:0] node_ch, input int hum, input int tmp,
                              input logic [7:0] term, input int spoil_at,
                              input logic [7:0] spoil, input bit ticks_inside);
      logic [7:0] fb[11];
      fb[0] = START_CHAR;
      fb[1] = node_ch;
      for (int k = 0; k < 4; k++) begin
         fb[5-k] = DIGIT_ZERO + 8'(hum % 10);
         hum = hum / 10;
         fb[9-k] = DIGIT_ZERO + 8'(tmp % 10);
         tmp = tmp / 10;
      end
      fb[10] = term;
      if (spoil_at != 0) fb[spoil_at] = spoil;
      foreach (fb[k]) begin
         push_item(CMD_BYTE, fb[k], 1'b1);
         // ticks between frame bytes must not disturb the parser
         if (ticks_inside && k < 10 && $urandom_range(0, 15) == 0)
            push_item(CMD_TICK, 8'($urandom), 1'b1);
      end
   endtask

   task automatic random_traffic(input int target);
      int         first;
      int         pick;
      int         slot;
      logic [7:0] nch;
      first = n_queued;
      while (n_queued - first < target) begin
         pick = $urandom_range(0, 99);
         slot = $urandom_range(0, 1);
         nch = (slot == 0) ? NODE_ONE : NODE_TWO;
         if (pick < 50) begin
            queue_frame(nch, pick_value(lim_hum[slot]), pick_value(lim_tmp[slot]),
                        END_CHAR, 0, 8'h00, 1'b1);
         end else if (pick < 62) begin
            repeat ($urandom_range(1, 3)) push_item(CMD_TICK, 8'($urandom), 1'b1);
         end else if (pick < 67) begin
            queue_frame(rand_other(NODE_ONE, NODE_TWO), $urandom_range(0, 9999),
                        $urandom_range(0, 9999), END_CHAR, 0, 8'h00, 1'b0);
         end else if (pick < 72) begin
            queue_frame(nch, $urandom_range(0, 9999), $urandom_range(0, 9999), END_CHAR,
                        $urandom_range(2, 9), rand_other(DIGIT_ZERO, DIGIT_ZERO + 8'd9),
                        1'b0);
         end else if (pick < 77) begin
            queue_frame(nch, $urandom_range(0, 9999), $urandom_range(0, 9999),
                        rand_other(END_CHAR, END_CHAR), 0, 8'h00, 1'b0);
         end else if (pick < 83) begin
            // abandoned partial frame, restarted by the next start byte
            push_item(CMD_BYTE, START_CHAR, 1'b1);
            repeat ($urandom_range(0, 9))
               push_item(CMD_BYTE, DIGIT_ZERO + 8'($urandom_range(0, 9)), 1'b1);
            queue_frame(nch, pick_value(lim_hum[slot]), pick_value(lim_tmp[slot]),
                        END_CHAR, 0, 8'h00, 1'b0);
         end else if (pick < 89) begin
            queue_frame(nch, $urandom_range(0, 9999), $urandom_range(0, 9999), END_CHAR,
                        0, 8'h00, 1'b0);
            repeat ($urandom_range(1, 4))
               push_item(CMD_BYTE, rand_other(START_CHAR, START_CHAR), 1'b0);
         end else begin
            repeat ($urandom_range(1, 5))
               push_item(logic'($urandom_range(0, 1)), 8'($urandom), 1'b0);
         end
      end
   endtask

   // lets the block go idle: nothing queued, on offer or outstanding
   task automatic settle();
      while (req_backlog.size() != 0 || req_live || due_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: program_regs(40, 39, 70, 69, 1);
            1: program_regs(0, 0, 0, 0, 1);
            2: program_regs(99, 99, 99, 99, 255);
            3: program_regs(127, 127, 127, 127, 1);
            4: program_regs($urandom_range(0, 99), $urandom_range(0, 99),
                            $urandom_range(0, 99), $urandom_range(0, 99), 0);
            default: program_regs($urandom_range(0, 99), $urandom_range(0, 99),
                                  $urandom_range(0, 99), $urandom_range(0, 99),
                                  $urandom_range(2, 10));
         endcase
         no_idle = (ph == 2 || ph == 5);
         if (ph == 0) begin
            push_item(CMD_BYTE, END_CHAR, 1'b1);
            push_item(CMD_BYTE, 8'hFF, 1'b1);
            push_item(CMD_BYTE, 8'h00, 1'b1);
            push_item(CMD_TICK, 8'hA5, 1'b1);
            queue_frame(NODE_ONE, 9999, 9999, END_CHAR, 0, 8'h00, 1'b0);
            queue_frame(NODE_TWO, 0, 0, END_CHAR, 0, 8'h00, 1'b0);
            push_item(CMD_TICK, 8'h5A, 1'b1);
         end else begin
            if (ph == 3) begin
               // every tick reports here, so the held-off receiver backs up the block
               hold_asks++;
               repeat (40) push_item(CMD_TICK, 8'($urandom), 1'b1);
            end
            random_traffic(ItemsPerPhase);
         end
         settle();
      end
      repeat (8) @(negedge clock);
      $display("Run: %0d requests, %0d frame updates and %0d alarm reports checked",
               n_requests, n_updates, n_reports);
      $display("Register settings: %0d, including zero, top-of-range and 7-bit limits",
               n_settings);
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
